/* rtl/delu_pkg.sv */
// shared types and constants for the directory entry name lookup unit
`default_nettype none

package delu_pkg;

    localparam int unsigned NAME_BYTES = 255;
    localparam int unsigned NAME_AW    = $clog2(NAME_BYTES);
    localparam int unsigned DIR_SIZE_W = 25;
    localparam int unsigned POS_W      = 25;
    localparam int unsigned OFF_W      = 16;

    localparam logic [DIR_SIZE_W-1:0] DIR_SIZE_RESET = 25'd1024;
    localparam logic [DIR_SIZE_W-1:0] MAX_DIR_BYTES  = 25'd16777216;

    localparam logic [OFF_W-1:0] OFF_INODE_LAST = 16'd3;
    localparam logic [OFF_W-1:0] OFF_RECLEN_LO  = 16'd4;
    localparam logic [OFF_W-1:0] OFF_RECLEN_HI  = 16'd5;
    localparam logic [OFF_W-1:0] OFF_NAME_LEN   = 16'd6;
    localparam logic [OFF_W-1:0] OFF_FILE_TYPE  = 16'd7;
    localparam logic [OFF_W-1:0] HDR_BYTES      = 16'd8;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    typedef struct packed {
        logic               wr_en;
        logic [NAME_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic [NAME_AW-1:0] rd_addr;
    } name_port_t;

endpackage

`default_nettype wire

/* rtl/directory_entry_name_lookup_unit.sv */
// top level of the directory entry name lookup unit
`default_nettype none

// Takes one byte per cycle on the s_ channel: first the target name (action 0, last on the
// final name byte), then the directory data (action 1, last on the final byte). Each byte
// is handled in the cycle it is accepted, so the sustained rate is one byte per clock; the
// result (found inode, not found, or malformed record) is loaded into the m_ output
// register when the last directory byte is accepted. The name store is a 255-byte memory
// whose registered read is addressed one byte ahead from the record offset counter, so the
// compare never waits on it. Input stalls only while a finished result sits in the output
// register and m_ready is low. dir_size is to be written through the cfg_ port between
// directories, which the block itself does not enforce, and resets to 1024.
module directory_entry_name_lookup_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [delu_pkg::DIR_SIZE_W-1:0]     cfg_dir_size,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic [7:0]                          s_data_byte,
    input  wire logic                                s_last,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [1:0]                               m_status,
    output logic [31:0]                              m_inode_number
);

    localparam int unsigned AW  = delu_pkg::NAME_AW;
    localparam int unsigned PW  = delu_pkg::POS_W;
    localparam int unsigned OW  = delu_pkg::OFF_W;

    logic [delu_pkg::DIR_SIZE_W-1:0] dir_size_reg;

    logic [AW-1:0]  name_len_reg,    name_len_next;
    logic           name_over_reg,   name_over_next;
    logic           name_closed_reg, name_closed_next;

    logic [PW-1:0]  byte_pos_reg,    byte_pos_next;
    logic [PW-1:0]  entry_start_reg, entry_start_next;
    logic [OW-1:0]  off_reg,         off_next;
    logic [31:0]    entry_inode_reg, entry_inode_next;
    logic [15:0]    rec_len_reg,     rec_len_next;
    logic [7:0]     ent_nlen_reg,    ent_nlen_next;
    logic           still_reg,       still_next;
    logic           finished_reg,    finished_next;
    logic [1:0]     held_status_reg, held_status_next;
    logic [31:0]    held_inode_reg,  held_inode_next;

    logic           m_valid_reg,     m_valid_next;
    logic [1:0]     m_status_reg,    m_status_next;
    logic [31:0]    m_inode_reg,     m_inode_next;

    delu_pkg::name_port_t name_port;
    logic [7:0]     name_rdata;

    logic           in_fire;
    logic           size_ok;
    logic           scan_active;
    logic           step_done;
    logic [AW-1:0]  name_base;
    logic [15:0]    rec_len_new;
    logic [PW-1:0]  hdr_end;
    logic [PW-1:0]  rec_end;
    logic [OW-1:0]  name_idx;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_inode_number = m_inode_reg;

    assign size_ok     = (dir_size_reg != '0) && (dir_size_reg <= delu_pkg::MAX_DIR_BYTES);
    assign scan_active = !finished_reg && size_ok && (byte_pos_reg < dir_size_reg);
    assign name_base   = name_closed_reg ? '0 : name_len_reg;
    assign rec_len_new = {s_data_byte, rec_len_reg[7:0]};
    assign hdr_end     = entry_start_reg + PW'(delu_pkg::HDR_BYTES);
    assign rec_end     = entry_start_reg + PW'(rec_len_new);
    assign name_idx    = off_reg - delu_pkg::HDR_BYTES;

    delu_name_store u_name_store (
        .aclk    (aclk),
        .port    (name_port),
        .rd_data (name_rdata)
    );

    always_comb begin
        name_len_next    = name_len_reg;
        name_over_next   = name_over_reg;
        name_closed_next = name_closed_reg;
        byte_pos_next    = byte_pos_reg;
        entry_start_next = entry_start_reg;
        off_next         = off_reg;
        entry_inode_next = entry_inode_reg;
        rec_len_next     = rec_len_reg;
        ent_nlen_next    = ent_nlen_reg;
        still_next       = still_reg;
        finished_next    = finished_reg;
        held_status_next = held_status_reg;
        held_inode_next  = held_inode_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_inode_next     = m_inode_reg;
        step_done        = 1'b0;
        name_port.wr_en   = 1'b0;
        name_port.wr_addr = name_base;
        name_port.wr_data = s_data_byte;

        if (in_fire) begin
            if (!s_action) begin
                // target name byte
                name_over_next   = name_closed_reg ? 1'b0 : name_over_reg;
                name_len_next    = name_base;
                if (name_base != AW'(delu_pkg::NAME_BYTES)) begin
                    name_port.wr_en = 1'b1;
                    name_len_next   = name_base + AW'(1);
                end else begin
                    name_over_next  = 1'b1;
                end
                name_closed_next = s_last;
            end else begin
                name_closed_next = 1'b1;
                if (scan_active) begin
                    if (off_reg == '0) begin
                        if (hdr_end > dir_size_reg) begin
                            finished_next    = 1'b1;
                            held_status_next = delu_pkg::STATUS_NOT_FOUND;
                            held_inode_next  = '0;
                            step_done        = 1'b1;
                        end else begin
                            entry_inode_next = {24'd0, s_data_byte};
                        end
                    end else if (off_reg <= delu_pkg::OFF_INODE_LAST) begin
                        case (off_reg[1:0])
                            2'd1: begin
                                entry_inode_next[15:8] = s_data_byte;
                            end
                            2'd2: begin
                                entry_inode_next[23:16] = s_data_byte;
                            end
                            2'd3: begin
                                entry_inode_next[31:24] = s_data_byte;
                            end
                            default: begin
                                entry_inode_next = entry_inode_reg;
                            end
                        endcase
                    end else if (off_reg == delu_pkg::OFF_RECLEN_LO) begin
                        rec_len_next = {8'd0, s_data_byte};
                    end else if (off_reg == delu_pkg::OFF_RECLEN_HI) begin
                        rec_len_next = rec_len_new;
                        if ((rec_len_new < delu_pkg::HDR_BYTES) || (rec_end > dir_size_reg)) begin
                            finished_next    = 1'b1;
                            held_status_next = delu_pkg::STATUS_MALFORMED;
                            held_inode_next  = '0;
                            step_done        = 1'b1;
                        end
                    end else if (off_reg == delu_pkg::OFF_NAME_LEN) begin
                        ent_nlen_next = s_data_byte;
                        still_next    = !name_over_reg && (s_data_byte == name_len_reg) &&
                                        ((16'(s_data_byte) + delu_pkg::HDR_BYTES) <= rec_len_reg);
                    end else if ((off_reg >= delu_pkg::HDR_BYTES) &&
                                 (name_idx < OW'(ent_nlen_reg)) && still_reg) begin
                        if (name_rdata != s_data_byte) begin
                            still_next = 1'b0;
                        end
                    end

                    if (!step_done) begin
                        if ((off_reg >= delu_pkg::OFF_FILE_TYPE) &&
                            (off_reg == delu_pkg::OFF_FILE_TYPE + OW'(ent_nlen_reg)) &&
                            still_next) begin
                            finished_next    = 1'b1;
                            held_status_next = delu_pkg::STATUS_FOUND;
                            held_inode_next  = entry_inode_reg;
                        end else begin
                            if ((off_reg >= delu_pkg::OFF_NAME_LEN) &&
                                ((off_reg + OW'(1)) == rec_len_reg)) begin
                                entry_start_next = byte_pos_reg + PW'(1);
                                off_next         = '0;
                            end else begin
                                off_next = off_reg + OW'(1);
                            end
                            byte_pos_next = byte_pos_reg + PW'(1);
                        end
                    end
                end

                if (s_last) begin
                    m_valid_next  = 1'b1;
                    m_status_next = held_status_next;
                    m_inode_next  = (held_status_next == delu_pkg::STATUS_FOUND) ?
                                    held_inode_next : '0;
                end
            end

            // scan state clears on every name byte and after each result
            if (!s_action || s_last) begin
                byte_pos_next    = '0;
                entry_start_next = '0;
                off_next         = '0;
                entry_inode_next = '0;
                rec_len_next     = '0;
                ent_nlen_next    = '0;
                still_next       = 1'b0;
                finished_next    = 1'b0;
                held_status_next = delu_pkg::STATUS_NOT_FOUND;
                held_inode_next  = '0;
            end
        end

        // prefetch the name byte for the offset of the next transfer
        name_port.rd_addr = off_next[AW-1:0] - AW'(delu_pkg::HDR_BYTES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_size_reg <= delu_pkg::DIR_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            dir_size_reg <= cfg_dir_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_len_reg    <= '0;
            name_over_reg   <= 1'b0;
            name_closed_reg <= 1'b1;
            byte_pos_reg    <= '0;
            entry_start_reg <= '0;
            off_reg         <= '0;
            entry_inode_reg <= '0;
            rec_len_reg     <= '0;
            ent_nlen_reg    <= '0;
            still_reg       <= 1'b0;
            finished_reg    <= 1'b0;
            held_status_reg <= delu_pkg::STATUS_NOT_FOUND;
            held_inode_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            name_len_reg    <= name_len_next;
            name_over_reg   <= name_over_next;
            name_closed_reg <= name_closed_next;
            byte_pos_reg    <= byte_pos_next;
            entry_start_reg <= entry_start_next;
            off_reg         <= off_next;
            entry_inode_reg <= entry_inode_next;
            rec_len_reg     <= rec_len_next;
            ent_nlen_reg    <= ent_nlen_next;
            still_reg       <= still_next;
            finished_reg    <= finished_next;
            held_status_reg <= held_status_next;
            held_inode_reg  <= held_inode_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_inode_reg  <= m_inode_next;
    end

    // last directory byte always yields a result
    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action && s_last) |=> m_valid)
        else $error("no result after last directory transfer");

    // name bytes never create a result
    a_no_result_on_name: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_action && !m_valid) |=> !m_valid)
        else $error("result after name transfer");

    // inode is zero unless found
    a_inode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != delu_pkg::STATUS_FOUND)) |-> (m_inode_number == '0))
        else $error("nonzero inode without a match");

    // status is one of the three codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status == delu_pkg::STATUS_FOUND) ||
                     (m_status == delu_pkg::STATUS_NOT_FOUND) ||
                     (m_status == delu_pkg::STATUS_MALFORMED)))
        else $error("bad status code");

endmodule

`default_nettype wire

/* rtl/delu_name_store.sv */
// target name byte store with registered read
`default_nettype none

module delu_name_store (
    input  wire logic                           aclk,
    input  wire delu_pkg::name_port_t           port,
    output logic [7:0]                          rd_data
);

    logic [7:0] mem [delu_pkg::NAME_BYTES];

    always_ff @(posedge aclk) begin
        if (port.wr_en) begin
            mem[port.wr_addr] <= port.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[port.rd_addr];
    end

endmodule

`default_nettype wire
